@@ rtl/spse_pkg.sv @@
// shared types, constants, key table and helpers for the shuangpin syllable encoder
`default_nettype none

package spse_pkg;

    localparam int MaxSyllable = 6;
    localparam int LenW        = $clog2(MaxSyllable + 1);
    localparam int PartMax     = 4;
    localparam int PartIdxW    = $clog2(PartMax);
    localparam int KeyCount    = 55;
    localparam int ResultMax   = 3;
    localparam int ResCntW     = $clog2(ResultMax + 1);

    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] Nul       = 8'h00;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       error;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [ResCntW-1:0]             count;
        out_item_t [0:ResultMax-1]      item;
    } res_bundle_t;

    typedef struct packed {
        logic [2:0]      len;
        logic [0:3][7:0] text;
        logic [7:0]      code;
    } key_entry_t;

    localparam key_entry_t KeyTable [KeyCount] = '{
        '{3'd1, '{"q", Nul, Nul, Nul}, "q"},
        '{3'd1, '{"w", Nul, Nul, Nul}, "w"},
        '{3'd1, '{"r", Nul, Nul, Nul}, "r"},
        '{3'd1, '{"t", Nul, Nul, Nul}, "t"},
        '{3'd2, '{"i", "u", Nul, Nul}, "q"},
        '{3'd2, '{"e", "i", Nul, Nul}, "w"},
        '{3'd1, '{"e", Nul, Nul, Nul}, "e"},
        '{3'd3, '{"u", "a", "n", Nul}, "r"},
        '{3'd2, '{"u", "e", Nul, Nul}, "t"},
        '{3'd1, '{"y", Nul, Nul, Nul}, "y"},
        '{3'd2, '{"u", "n", Nul, Nul}, "y"},
        '{3'd1, '{"u", Nul, Nul, Nul}, "u"},
        '{3'd2, '{"s", "h", Nul, Nul}, "u"},
        '{3'd1, '{"i", Nul, Nul, Nul}, "i"},
        '{3'd2, '{"c", "h", Nul, Nul}, "i"},
        '{3'd1, '{"o", Nul, Nul, Nul}, "o"},
        '{3'd2, '{"u", "o", Nul, Nul}, "o"},
        '{3'd1, '{"p", Nul, Nul, Nul}, "p"},
        '{3'd2, '{"i", "e", Nul, Nul}, "p"},
        '{3'd1, '{"a", Nul, Nul, Nul}, "a"},
        '{3'd1, '{"s", Nul, Nul, Nul}, "s"},
        '{3'd3, '{"o", "n", "g", Nul}, "s"},
        '{3'd4, '{"i", "o", "n", "g"}, "s"},
        '{3'd1, '{"d", Nul, Nul, Nul}, "d"},
        '{3'd2, '{"a", "i", Nul, Nul}, "d"},
        '{3'd1, '{"f", Nul, Nul, Nul}, "f"},
        '{3'd2, '{"e", "n", Nul, Nul}, "f"},
        '{3'd1, '{"g", Nul, Nul, Nul}, "g"},
        '{3'd3, '{"e", "n", "g", Nul}, "g"},
        '{3'd1, '{"h", Nul, Nul, Nul}, "h"},
        '{3'd3, '{"a", "n", "g", Nul}, "h"},
        '{3'd1, '{"j", Nul, Nul, Nul}, "j"},
        '{3'd2, '{"a", "n", Nul, Nul}, "j"},
        '{3'd1, '{"k", Nul, Nul, Nul}, "k"},
        '{3'd3, '{"u", "a", "i", Nul}, "k"},
        '{3'd3, '{"i", "n", "g", Nul}, "k"},
        '{3'd1, '{"l", Nul, Nul, Nul}, "l"},
        '{3'd4, '{"u", "a", "n", "g"}, "l"},
        '{3'd4, '{"i", "a", "n", "g"}, "l"},
        '{3'd1, '{"z", Nul, Nul, Nul}, "z"},
        '{3'd2, '{"o", "u", Nul, Nul}, "z"},
        '{3'd1, '{"x", Nul, Nul, Nul}, "x"},
        '{3'd2, '{"i", "a", Nul, Nul}, "x"},
        '{3'd2, '{"u", "a", Nul, Nul}, "x"},
        '{3'd1, '{"c", Nul, Nul, Nul}, "c"},
        '{3'd2, '{"a", "o", Nul, Nul}, "c"},
        '{3'd1, '{"v", Nul, Nul, Nul}, "v"},
        '{3'd2, '{"z", "h", Nul, Nul}, "v"},
        '{3'd2, '{"u", "i", Nul, Nul}, "v"},
        '{3'd1, '{"b", Nul, Nul, Nul}, "b"},
        '{3'd2, '{"i", "n", Nul, Nul}, "b"},
        '{3'd1, '{"n", Nul, Nul, Nul}, "n"},
        '{3'd3, '{"i", "a", "o", Nul}, "n"},
        '{3'd1, '{"m", Nul, Nul, Nul}, "m"},
        '{3'd3, '{"i", "a", "n", Nul}, "m"}
    };

    function automatic logic is_vowel(input logic [7:0] b);
        return (b == "a") || (b == "e") || (b == "i") || (b == "o") || (b == "u");
    endfunction

    function automatic logic is_separator(input in_item_t it);
        return it.end_of_input || (it.ch == ChSpace) || (it.ch == ChNewline);
    endfunction

endpackage

`default_nettype wire

@@ rtl/spse_key_lookup.sv @@
// key table match of one syllable part of up to four bytes
`default_nettype none

module spse_key_lookup (
    input  logic [0:spse_pkg::PartMax-1][7:0] text,
    input  logic [spse_pkg::LenW-1:0]         n,
    output logic                              hit,
    output logic [7:0]                        code
);

    always_comb
    begin
        hit  = 1'b0;
        code = 8'h00;
        for (int e = 0; e < spse_pkg::KeyCount; e++)
        begin
            logic m;
            m = (spse_pkg::LenW'(spse_pkg::KeyTable[e].len) == n);
            for (int j = 0; j < spse_pkg::PartMax; j++)
            begin
                if ((spse_pkg::LenW'(j) < n) && (text[j] != spse_pkg::KeyTable[e].text[j]))
                begin
                    m = 1'b0;
                end
            end
            // entries are unique, so at most one matches
            if (m)
            begin
                hit  = 1'b1;
                code = code | spse_pkg::KeyTable[e].code;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/spse_syllable.sv @@
// syllable state and result formation for one separator item
`default_nettype none

module spse_syllable (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  spse_pkg::in_item_t    item,
    output spse_pkg::res_bundle_t bundle
);

    localparam int Lw = spse_pkg::LenW;

    logic [7:0]    buf_reg [spse_pkg::MaxSyllable];
    logic [7:0]    fin_reg [spse_pkg::PartMax];
    logic [Lw-1:0] len_reg, len_next;
    logic [Lw-1:0] k_reg, k_next;
    logic          ovf_reg, ovf_next;
    logic          vowel_reg, vowel_next;

    logic          sep;
    logic          store;
    logic          fin_store;
    logic [Lw-1:0] fin_pos;
    logic [7:0]    sep_char;

    logic [0:spse_pkg::PartMax-1][7:0] text_a, text_b;
    logic [Lw-1:0] n_a, n_b;
    logic          hit_a, hit_b;
    logic [7:0]    code_a, code_b;
    spse_pkg::out_item_t res_a, res_b, res_err;

    assign sep      = spse_pkg::is_separator(item);
    assign sep_char = item.end_of_input ? spse_pkg::ChNewline : item.ch;
    assign store    = step && !sep && (len_reg < Lw'(spse_pkg::MaxSyllable));
    // final part starts at the first vowel
    assign fin_pos  = len_reg - (vowel_reg ? k_reg : len_reg);
    assign fin_store = store && (vowel_reg || spse_pkg::is_vowel(item.ch))
                       && (fin_pos < Lw'(spse_pkg::PartMax));

    always_comb
    begin
        len_next   = len_reg;
        k_next     = k_reg;
        ovf_next   = ovf_reg;
        vowel_next = vowel_reg;
        if (step && sep)
        begin
            len_next   = '0;
            ovf_next   = 1'b0;
            vowel_next = 1'b0;
        end
        else if (store)
        begin
            len_next = len_reg + Lw'(1);
            if (!vowel_reg && spse_pkg::is_vowel(item.ch))
            begin
                vowel_next = 1'b1;
                k_next     = len_reg;
            end
        end
        else if (step)
        begin
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            k_reg     <= '0;
            ovf_reg   <= 1'b0;
            vowel_reg <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            k_reg     <= k_next;
            ovf_reg   <= ovf_next;
            vowel_reg <= vowel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            buf_reg[len_reg[$clog2(spse_pkg::MaxSyllable)-1:0]] <= item.ch;
        end
        if (fin_store)
        begin
            fin_reg[fin_pos[spse_pkg::PartIdxW-1:0]] <= item.ch;
        end
    end

    always_comb
    begin
        for (int j = 0; j < spse_pkg::PartMax; j++)
        begin
            text_a[j] = buf_reg[j];
            text_b[j] = fin_reg[j];
        end
    end

    // whole syllable when it opens with a vowel, otherwise the initial
    assign n_a = (k_reg == '0) ? len_reg : k_reg;
    assign n_b = len_reg - k_reg;

    spse_key_lookup u_lookup_a (
        .text (text_a),
        .n    (n_a),
        .hit  (hit_a),
        .code (code_a)
    );

    spse_key_lookup u_lookup_b (
        .text (text_b),
        .n    (n_b),
        .hit  (hit_b),
        .code (code_b)
    );

    assign res_a   = '{out_char: hit_a ? code_a : 8'h00, error: !hit_a, last: 1'b0};
    assign res_b   = '{out_char: hit_b ? code_b : 8'h00, error: !hit_b, last: 1'b0};
    assign res_err = '{out_char: 8'h00, error: 1'b1, last: 1'b0};

    always_comb
    begin
        bundle.count   = spse_pkg::ResCntW'(3);
        bundle.item[0] = res_err;
        bundle.item[1] = res_err;
        bundle.item[2] = '{out_char: sep_char, error: 1'b0, last: 1'b1};
        if ((len_reg == '0) && !ovf_reg)
        begin
            bundle.count   = spse_pkg::ResCntW'(1);
            bundle.item[0] = '{out_char: sep_char, error: 1'b0, last: 1'b1};
        end
        else if (ovf_reg)
        begin
            bundle.item[0] = res_err;
            bundle.item[1] = res_err;
        end
        else if (len_reg == Lw'(1))
        begin
            bundle.item[0] = '{out_char: buf_reg[0], error: 1'b0, last: 1'b0};
            bundle.item[1] = '{out_char: buf_reg[0], error: 1'b0, last: 1'b0};
        end
        else if (len_reg == Lw'(2))
        begin
            bundle.item[0] = '{out_char: buf_reg[0], error: 1'b0, last: 1'b0};
            bundle.item[1] = '{out_char: buf_reg[1], error: 1'b0, last: 1'b0};
        end
        else if (!vowel_reg)
        begin
            bundle.item[0] = res_err;
            bundle.item[1] = res_err;
        end
        else if (k_reg == '0)
        begin
            bundle.item[0] = '{out_char: buf_reg[0], error: 1'b0, last: 1'b0};
            bundle.item[1] = res_a;
        end
        else
        begin
            bundle.item[0] = res_a;
            bundle.item[1] = res_b;
        end
    end

endmodule

`default_nettype wire

@@ rtl/spse_result_queue.sv @@
// three-entry result queue whose head is the output register
`default_nettype none

module spse_result_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  spse_pkg::res_bundle_t bundle,
    output logic                  load_ok,
    output logic                  result_valid,
    input  logic                  result_stall,
    output spse_pkg::out_item_t   result
);

    spse_pkg::out_item_t               q_reg [spse_pkg::ResultMax];
    logic [spse_pkg::ResCntW-1:0]      cnt_reg, cnt_next;
    logic                              take;

    assign take         = (cnt_reg != '0) && !result_stall;
    assign load_ok      = (cnt_reg == '0) || ((cnt_reg == spse_pkg::ResCntW'(1)) && take);
    assign result_valid = (cnt_reg != '0);
    assign result       = q_reg[0];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = bundle.count;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - spse_pkg::ResCntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < spse_pkg::ResultMax; i++)
            begin
                q_reg[i] <= bundle.item[i];
            end
        end
        else if (take)
        begin
            for (int i = 0; i < spse_pkg::ResultMax - 1; i++)
            begin
                q_reg[i] <= q_reg[i + 1];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/shuangpin_syllable_encoder_core.sv @@
// top level of the shuangpin syllable encoder: input register, syllable logic, result queue
// path: an accepted item waits in the input register; a separator's results load into the
//   result queue, whose head register drives the output
// throughput: letters go at one item per cycle unless a separator waits; a separator needs
//   the queue drained and loads one result (empty syllable) or three (codes plus separator)
// reset: rst_n clears the input register valid, syllable length, first-vowel index, vowel and
//   overflow flags and the queue count; buffered letters are left as they are
`default_nettype none

module shuangpin_syllable_encoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  spse_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output spse_pkg::out_item_t result
);

    // input register
    logic                  in_valid_reg, in_valid_next;
    spse_pkg::in_item_t    in_reg;

    logic                  accept;
    logic                  in_sep;
    logic                  adv;
    logic                  load_ok;
    spse_pkg::res_bundle_t bundle;

    assign in_sep = spse_pkg::is_separator(in_reg);

    // a letter always moves on; a separator waits until the queue is (about to be) empty
    assign adv        = in_valid_reg && (!in_sep || load_ok);
    assign item_stall = in_valid_reg && !adv;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (adv)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
        end
    end

    // syllable buffer and the results a separator item causes
    spse_syllable u_syllable (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (adv),
        .item   (in_reg),
        .bundle (bundle)
    );

    // results leave one per cycle from the head of the queue while result_stall is low
    spse_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (adv && in_sep),
        .bundle       (bundle),
        .load_ok      (load_ok),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // no stall while the input register is empty
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !item_stall)
        else $error("input stalled with empty input register");

    // a separator leaving the input register always produces a result
    a_sep_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_sep) |=> result_valid)
        else $error("separator produced no result");

    // once the last item of a group goes, the queue is empty unless a new group loads
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && result.last) |=>
            (result_valid == $past(adv && in_sep)))
        else $error("results remain after last item");

endmodule

`default_nettype wire

@@ sim/shuangpin_syllable_encoder_core_tb.sv @@
// self-checking testbench for the shuangpin syllable encoder core
`timescale 1ns / 1ps

module shuangpin_syllable_encoder_core_tb;

    localparam int SylDepth    = 6;      // letters the syllable buffer holds
    localparam int RandomItems = 320;    // random items after the directed table
    localparam int DrainCycles = 20;     // quiet cycles after the last expected result
    localparam int DrainLimit  = 2000;   // give up waiting for stragglers after this
    localparam int DirCount    = 27;

    // one row of the directed table; typed rows carry their results, the rest use the predictor
    typedef struct packed {
        logic [7:0]      ch;
        logic            eoi;
        logic            typed;
        logic [1:0]      n_res;
        logic [0:2][7:0] exp_char;
        logic [0:2]      exp_err;
    } dir_row_t;

    localparam dir_row_t DirRows [DirCount] = '{
        // separator straight after reset: separator alone
        '{spse_pkg::ChSpace,   1'b0, 1'b1, 2'd1, '{spse_pkg::ChSpace, 8'h00, 8'h00},   3'b000},
        // end of input on an empty buffer, ch at its top value
        '{8'hFF,               1'b1, 1'b1, 2'd1, '{spse_pkg::ChNewline, 8'h00, 8'h00}, 3'b000},
        // one-letter syllable is doubled
        '{"a",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{spse_pkg::ChNewline, 1'b0, 1'b1, 2'd3, '{"a", "a", spse_pkg::ChNewline},     3'b000},
        // two bytes at the extremes are copied; end of input wins over a space in ch
        '{8'h00,               1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{8'hFF,               1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{spse_pkg::ChSpace,   1'b1, 1'b1, 2'd3, '{8'h00, 8'hFF, spse_pkg::ChNewline}, 3'b000},
        // three letters and no vowel: both code bytes faulted
        '{"x",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{"y",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{"z",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{spse_pkg::ChSpace,   1'b0, 1'b1, 2'd3, '{8'h00, 8'h00, spse_pkg::ChSpace},   3'b110},
        // seven letters overflow the buffer
        '{"a",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{"b",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{"c",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{"d",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{"e",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{"f",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{"g",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{spse_pkg::ChNewline, 1'b0, 1'b1, 2'd3, '{8'h00, 8'h00, spse_pkg::ChNewline}, 3'b110},
        // syllable opening on a vowel: first letter, then key of the whole syllable
        '{"a",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{"n",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{"g",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{spse_pkg::ChSpace,   1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        // initial missing from the table, final still found
        '{"q",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{"x",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{"a",                 1'b0, 1'b0, 2'd0, '0,                                   3'b000},
        '{8'h00,               1'b1, 1'b0, 2'd0, '0,                                   3'b000}
    };

    // pinyin pieces for well-formed random syllables
    string onsets [23] = '{"b", "p", "m", "f", "d", "t", "n", "l", "g", "k", "h", "j",
                           "q", "x", "zh", "ch", "sh", "r", "z", "c", "s", "y", "w"};
    string rimes [33] = '{"a", "o", "e", "i", "u", "v", "ai", "ei", "ui", "ao", "ou",
                          "iu", "ie", "ue", "er", "an", "en", "in", "un", "ang", "eng",
                          "ing", "ong", "ia", "ua", "uo", "iao", "ian", "iang", "iong",
                          "uan", "uang", "uai"};

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    spse_pkg::in_item_t  item         = '0;
    logic                result_valid;
    logic                result_stall = 1'b1;
    spse_pkg::out_item_t result;

    // predictor state: letters of the syllable in progress
    logic [7:0]  syl_buf [SylDepth];
    int unsigned syl_len  = 0;
    bit          syl_ovf  = 1'b0;

    spse_pkg::out_item_t pending_codes [$];   // expected output bytes, oldest first
    int unsigned fail_count = 0;
    bit          calm       = 1'b0;   // while set neither side idles

    always #5 clk = ~clk;

    shuangpin_syllable_encoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic int unsigned idle_cycles();
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic bit is_pinyin_vowel(logic [7:0] b);
        return b == "a" || b == "e" || b == "i" || b == "o" || b == "u";
    endfunction

    // key of syl_buf[start +: n], or a faulted zero byte when the part is not in the table
    function automatic void key_lookup(int unsigned start, int unsigned n,
                                       ref spse_pkg::out_item_t res [$]);
        logic [31:0] part;
        logic [7:0]  code;
        part = '0;
        code = spse_pkg::Nul;
        if (n >= 1 && n <= 4 && start + n <= syl_len) begin
            for (int j = 0; j < n; j++)
                part = {part[23:0], syl_buf[start + j]};
            case ({3'(n), part})
                {3'd1, 24'd0, "q"}, {3'd2, 16'd0, "iu"}:                        code = "q";
                {3'd1, 24'd0, "w"}, {3'd2, 16'd0, "ei"}:                        code = "w";
                {3'd1, 24'd0, "e"}:                                             code = "e";
                {3'd1, 24'd0, "r"}, {3'd3, 8'd0, "uan"}:                        code = "r";
                {3'd1, 24'd0, "t"}, {3'd2, 16'd0, "ue"}:                        code = "t";
                {3'd1, 24'd0, "y"}, {3'd2, 16'd0, "un"}:                        code = "y";
                {3'd1, 24'd0, "u"}, {3'd2, 16'd0, "sh"}:                        code = "u";
                {3'd1, 24'd0, "i"}, {3'd2, 16'd0, "ch"}:                        code = "i";
                {3'd1, 24'd0, "o"}, {3'd2, 16'd0, "uo"}:                        code = "o";
                {3'd1, 24'd0, "p"}, {3'd2, 16'd0, "ie"}:                        code = "p";
                {3'd1, 24'd0, "a"}:                                             code = "a";
                {3'd1, 24'd0, "s"}, {3'd3, 8'd0, "ong"}, {3'd4, "iong"}:        code = "s";
                {3'd1, 24'd0, "d"}, {3'd2, 16'd0, "ai"}:                        code = "d";
                {3'd1, 24'd0, "f"}, {3'd2, 16'd0, "en"}:                        code = "f";
                {3'd1, 24'd0, "g"}, {3'd3, 8'd0, "eng"}:                        code = "g";
                {3'd1, 24'd0, "h"}, {3'd3, 8'd0, "ang"}:                        code = "h";
                {3'd1, 24'd0, "j"}, {3'd2, 16'd0, "an"}:                        code = "j";
                {3'd1, 24'd0, "k"}, {3'd3, 8'd0, "uai"}, {3'd3, 8'd0, "ing"}:   code = "k";
                {3'd1, 24'd0, "l"}, {3'd4, "uang"}, {3'd4, "iang"}:             code = "l";
                {3'd1, 24'd0, "z"}, {3'd2, 16'd0, "ou"}:                        code = "z";
                {3'd1, 24'd0, "x"}, {3'd2, 16'd0, "ia"}, {3'd2, 16'd0, "ua"}:   code = "x";
                {3'd1, 24'd0, "c"}, {3'd2, 16'd0, "ao"}:                        code = "c";
                {3'd1, 24'd0, "v"}, {3'd2, 16'd0, "zh"}, {3'd2, 16'd0, "ui"}:   code = "v";
                {3'd1, 24'd0, "b"}, {3'd2, 16'd0, "in"}:                        code = "b";
                {3'd1, 24'd0, "n"}, {3'd3, 8'd0, "iao"}:                        code = "n";
                {3'd1, 24'd0, "m"}, {3'd3, 8'd0, "ian"}:                        code = "m";
                default:                                                        code = spse_pkg::Nul;
            endcase
        end
        // no key in the table is zero, so a zero code always means a fault
        res.push_back('{code, code == spse_pkg::Nul, 1'b0});
    endfunction

    // shuangpin bytes caused by one accepted item; updates the syllable buffer
    function automatic void shuangpin_codes(spse_pkg::in_item_t it,
                                            ref spse_pkg::out_item_t res [$]);
        logic [7:0]  sep;
        int unsigned k;
        res.delete();
        if (!it.end_of_input && it.ch != spse_pkg::ChSpace && it.ch != spse_pkg::ChNewline) begin
            // any other byte is a letter; a full buffer drops it and marks overflow
            if (syl_len < SylDepth) begin
                syl_buf[syl_len] = it.ch;
                syl_len++;
            end
            else
                syl_ovf = 1'b1;
            return;
        end
        sep = it.end_of_input ? spse_pkg::ChNewline : it.ch;
        if (syl_ovf) begin
            res.push_back('{spse_pkg::Nul, 1'b1, 1'b0});
            res.push_back('{spse_pkg::Nul, 1'b1, 1'b0});
        end
        else if (syl_len == 1) begin
            res.push_back('{syl_buf[0], 1'b0, 1'b0});
            res.push_back('{syl_buf[0], 1'b0, 1'b0});
        end
        else if (syl_len == 2) begin
            res.push_back('{syl_buf[0], 1'b0, 1'b0});
            res.push_back('{syl_buf[1], 1'b0, 1'b0});
        end
        else if (syl_len >= 3) begin
            k = 0;
            while (k < syl_len && !is_pinyin_vowel(syl_buf[k]))
                k++;
            if (k == syl_len) begin
                res.push_back('{spse_pkg::Nul, 1'b1, 1'b0});
                res.push_back('{spse_pkg::Nul, 1'b1, 1'b0});
            end
            else if (k == 0) begin
                res.push_back('{syl_buf[0], 1'b0, 1'b0});
                key_lookup(0, syl_len, res);
            end
            else begin
                key_lookup(0, k, res);
                key_lookup(k, syl_len - k, res);
            end
        end
        res.push_back('{sep, 1'b0, 1'b1});
        syl_len = 0;
        syl_ovf = 1'b0;
    endfunction

    function automatic spse_pkg::in_item_t random_separator();
        case ($urandom_range(0, 2))
            0:       return '{spse_pkg::ChSpace, 1'b0};
            1:       return '{spse_pkg::ChNewline, 1'b0};
            default: return '{8'($urandom), 1'b1};
        endcase
    endfunction

    // offer one item after a random gap, then queue what it should produce
    task automatic send_item(spse_pkg::in_item_t it, dir_row_t row);
        spse_pkg::out_item_t res [$];
        int unsigned         gap;
        gap = idle_cycles();
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        // the predictor always runs so its buffer tracks the block
        shuangpin_codes(it, res);
        if (row.typed) begin
            for (int i = 0; i < row.n_res; i++)
                pending_codes.push_back('{row.exp_char[i], row.exp_err[i],
                                          i == int'(row.n_res) - 1});
        end
        else begin
            foreach (res[i])
                pending_codes.push_back(res[i]);
        end
    endtask

    // result side: random stalls, and every accepted item checked against the oldest expectation
    initial begin
        spse_pkg::out_item_t want;
        int unsigned         hold;
        forever begin
            hold = idle_cycles();
            if (hold > 0) begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (result_valid !== 1'b1);
            if (pending_codes.size() == 0)
                report_mismatch("unexpected result", result.out_char, 0);
            else begin
                want = pending_codes.pop_front();
                if (result.out_char !== want.out_char)
                    report_mismatch("out_char", result.out_char, want.out_char);
                if (result.error !== want.error)
                    report_mismatch("error", result.error, want.error);
                if (result.last !== want.last)
                    report_mismatch("last", result.last, want.last);
            end
        end
    end

    // reset, directed table, random pinyin text, drain and verdict
    initial begin
        spse_pkg::in_item_t grp [$];
        string              onset;
        string              rime;
        int unsigned        sent;
        int unsigned        len;
        int unsigned        waited;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DirRows[i])
            send_item('{DirRows[i].ch, DirRows[i].eoi}, DirRows[i]);

        sent = 0;
        while (sent < RandomItems) begin
            // now and then switch between idling and back-to-back stretches
            if ($urandom_range(0, 5) == 0)
                calm = ($urandom_range(0, 3) == 0);
            grp.delete();
            case ($urandom_range(0, 9))
                7: begin
                    // arbitrary bytes, separators among them included
                    len = $urandom_range(0, 8);
                    repeat (len) grp.push_back('{8'($urandom), 1'b0});
                    grp.push_back(random_separator());
                end
                8: begin
                    // lower-case junk, often vowel-less or overlong
                    len = $urandom_range(3, 8);
                    repeat (len) grp.push_back('{8'("a" + $urandom_range(0, 25)), 1'b0});
                    grp.push_back(random_separator());
                end
                9: begin
                    // runs of separators on an empty buffer
                    len = $urandom_range(1, 3);
                    repeat (len) grp.push_back(random_separator());
                end
                default: begin
                    // well-formed syllable, sometimes with no initial
                    onset = ($urandom_range(0, 4) != 0) ?
                            onsets[$urandom_range(0, $size(onsets) - 1)] : "";
                    rime  = rimes[$urandom_range(0, $size(rimes) - 1)];
                    for (int j = 0; j < onset.len(); j++)
                        grp.push_back('{onset[j], 1'b0});
                    for (int j = 0; j < rime.len(); j++)
                        grp.push_back('{rime[j], 1'b0});
                    grp.push_back(random_separator());
                end
            endcase
            foreach (grp[i])
                send_item(grp[i], '0);
            sent += grp.size();
        end
        item_valid <= 1'b0;

        // let the last results through, then watch for anything extra
        waited = 0;
        while (pending_codes.size() != 0 && waited < DrainLimit) begin
            @(posedge clk);
            waited++;
        end
        repeat (DrainCycles) @(posedge clk);
        if (pending_codes.size() != 0)
            report_mismatch("results never arrived", 0, pending_codes.size());

        if (fail_count == 0)
            $display("shuangpin_syllable_encoder_core regression: pass");
        else
            $display("shuangpin_syllable_encoder_core regression: fail");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("shuangpin_syllable_encoder_core regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/spse_pkg.sv
rtl/spse_key_lookup.sv
rtl/spse_syllable.sv
rtl/spse_result_queue.sv
rtl/shuangpin_syllable_encoder_core.sv
sim/shuangpin_syllable_encoder_core_tb.sv
